### rtl/joystick_differential_drive_mixer_core_assert.svh
// Assertion helpers for the mixer core. Both sample on the rising edge of clk
// and are disabled while arst_n is low.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_CORE_ASSERT_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_CORE_ASSERT_SVH

// Same-cycle implication.
`define JDDM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define JDDM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/jddm_pkg.sv
package jddm_pkg;

	localparam int AXIS_BITS  = 12;
	localparam int GAIN_W     = 24;
	localparam int PADDR_W    = 5;

	localparam logic [AXIS_BITS-1:0] CENTRE = AXIS_BITS'(1 << (AXIS_BITS - 1));

	localparam logic       REQ_SAMPLE = 1'b0;
	localparam logic       REQ_TICK   = 1'b1;

	localparam logic [1:0] DIR_OFF = 2'd0;
	localparam logic [1:0] DIR_FWD = 2'd1;
	localparam logic [1:0] DIR_REV = 2'd2;

	localparam logic [2:0] REG_DZ_LO      = 3'd0;
	localparam logic [2:0] REG_DZ_HI      = 3'd1;
	localparam logic [2:0] REG_STICK_GAIN = 3'd2;
	localparam logic [2:0] REG_TURN_GAIN  = 3'd3;
	localparam logic [2:0] REG_DRIVE_GAIN = 3'd4;
	localparam logic [2:0] REG_TIMEOUT    = 3'd5;

	typedef struct packed {
		logic                 req_type;
		logic [AXIS_BITS-1:0] stick_x;
		logic [AXIS_BITS-1:0] stick_y;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  dir_left;
		logic [15:0] duty_left;
		logic [1:0]  dir_right;
		logic [15:0] duty_right;
		logic        link_on;
	} out_item_t;

	typedef struct packed {
		logic [AXIS_BITS-1:0] dz_lo;
		logic [AXIS_BITS-1:0] dz_hi;
		logic [15:0]          stick_gain;
		logic [15:0]          turn_gain;
		logic [23:0]          drive_gain;
		logic [31:0]          timeout;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FWD,
		ST_TRN,
		ST_TURN,
		ST_MIX,
		ST_LEFT,
		ST_RIGHT,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic load;
		st_t  st;
	} dp_ctl_t;

endpackage

### rtl/joystick_differential_drive_mixer_core.sv
// Channel  Handshake              Payload     Direction
// in       in_valid / in_stall    in_item_t   sample (req_type 0) or tick
// out      out_valid / out_stall  out_item_t  directions, duties, link_on
// cfg      psel/penable/pwrite    pwdata      six registers at 4*index
//
// A sample runs FWD, TRN, TURN, MIX, LEFT, RIGHT and EMIT in turn: the single
// shared multiplier is used five times in sequence plus a mix and an emit step.
// A tick stays idle, or on a timeout goes to EMIT and emits a switch-off item.
// Reset (arst_n low) clears the sequencer, idle counter, held duties and
// output valid; registers return to their defaults.
// A stalled output item holds; the emit step waits until the output slot frees.
module joystick_differential_drive_mixer_core
	import jddm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	`include "joystick_differential_drive_mixer_core_assert.svh"

	cfg_t        cfg;
	dp_ctl_t     ctl;
	logic        emit, emit_link, out_free;
	logic [1:0]  dp_dir_left, dp_dir_right;
	logic [15:0] dp_duty_left, dp_duty_right;
	logic        out_valid_q;
	out_item_t   out_q;

	// Output slot is free when empty or being taken this cycle.
	assign out_free = !out_valid_q || !out_stall;

	jddm_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	jddm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (in_data.req_type),
		.timeout   (cfg.timeout),
		.out_free  (out_free),
		.in_stall  (in_stall),
		.ctl       (ctl),
		.emit      (emit),
		.emit_link (emit_link)
	);

	jddm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.ctl        (ctl),
		.stick_x    (in_data.stick_x),
		.stick_y    (in_data.stick_y),
		.dir_left   (dp_dir_left),
		.duty_left  (dp_duty_left),
		.dir_right  (dp_dir_right),
		.duty_right (dp_duty_right)
	);

	// Output register: load on emit, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			// A timeout switches both motors off but reports the held duties.
			out_q.dir_left   <= emit_link ? dp_dir_left : DIR_OFF;
			out_q.duty_left  <= dp_duty_left;
			out_q.dir_right  <= emit_link ? dp_dir_right : DIR_OFF;
			out_q.duty_right <= dp_duty_right;
			out_q.link_on    <= emit_link;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`JDDM_ASSERT_NEXT(a_sample_busy, in_valid && !in_stall && in_data.req_type == REQ_SAMPLE, in_stall, "sample accepted but block not busy")
	`JDDM_ASSERT_NOW(a_timeout_off, out_valid && !out_data.link_on, out_data.dir_left == DIR_OFF && out_data.dir_right == DIR_OFF, "timeout item with a motor on")
	`JDDM_ASSERT_NOW(a_off_no_duty, out_valid && out_data.link_on && out_data.dir_left == DIR_OFF, out_data.duty_left == 16'd0, "left off with nonzero duty")
	`JDDM_ASSERT_NOW(a_emit_slot, emit, !out_valid_q || !out_stall, "emit over a stalled item")

endmodule

### rtl/jddm_cfg_regs.sv
module jddm_cfg_regs
	import jddm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[PADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dz_lo      <= AXIS_BITS'(1948);
			cfg_q.dz_hi      <= AXIS_BITS'(2148);
			cfg_q.stick_gain <= 16'd3200;
			cfg_q.turn_gain  <= 16'd256;
			cfg_q.drive_gain <= 24'd25600;
			cfg_q.timeout    <= 32'd200;
		end else if (wr_en) begin
			unique case (idx)
				REG_DZ_LO:      cfg_q.dz_lo      <= pwdata[AXIS_BITS-1:0];
				REG_DZ_HI:      cfg_q.dz_hi      <= pwdata[AXIS_BITS-1:0];
				REG_STICK_GAIN: cfg_q.stick_gain <= pwdata[15:0];
				REG_TURN_GAIN:  cfg_q.turn_gain  <= pwdata[15:0];
				REG_DRIVE_GAIN: cfg_q.drive_gain <= pwdata[23:0];
				REG_TIMEOUT:    cfg_q.timeout    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DZ_LO:      prdata = 32'(cfg_q.dz_lo);
			REG_DZ_HI:      prdata = 32'(cfg_q.dz_hi);
			REG_STICK_GAIN: prdata = 32'(cfg_q.stick_gain);
			REG_TURN_GAIN:  prdata = 32'(cfg_q.turn_gain);
			REG_DRIVE_GAIN: prdata = 32'(cfg_q.drive_gain);
			REG_TIMEOUT:    prdata = cfg_q.timeout;
			default:        prdata = 32'd0;
		endcase
	end

endmodule

### rtl/jddm_datapath.sv
module jddm_datapath
	import jddm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  dp_ctl_t              ctl,
	input  logic [AXIS_BITS-1:0] stick_x,
	input  logic [AXIS_BITS-1:0] stick_y,
	output logic [1:0]           dir_left,
	output logic [15:0]          duty_left,
	output logic [1:0]           dir_right,
	output logic [15:0]          duty_right
);

	localparam int SUM_W  = AXIS_BITS + 10;
	localparam int PROD_W = AXIS_BITS + GAIN_W;

	typedef struct packed {
		logic       neg;
		logic [6:0] mag;
	} side_t;

	typedef struct packed {
		logic                 neg;
		logic [AXIS_BITS-1:0] mag;
	} axis_t;

	function automatic axis_t axis_center(input logic [AXIS_BITS-1:0] v,
			input logic [AXIS_BITS-1:0] lo, input logic [AXIS_BITS-1:0] hi);
		axis_t r;
		if (v >= lo && v <= hi) begin
			r.neg = 1'b0;
			r.mag = '0;
		end else if (v < CENTRE) begin
			r.neg = 1'b1;
			r.mag = CENTRE - v;
		end else begin
			r.neg = 1'b0;
			r.mag = v - CENTRE;
		end
		return r;
	endfunction

	function automatic side_t clamp_side(input logic signed [SUM_W-1:0] p);
		side_t r;
		if (p > SUM_W'(100)) begin
			r.neg = 1'b0;
			r.mag = 7'd100;
		end else if (p < -SUM_W'(100)) begin
			r.neg = 1'b1;
			r.mag = 7'd100;
		end else if (p < 0) begin
			r.neg = 1'b1;
			r.mag = 7'(-p);
		end else begin
			r.neg = 1'b0;
			r.mag = 7'(p);
		end
		return r;
	endfunction

	logic [AXIS_BITS-1:0]   x_q, y_q;
	logic [AXIS_BITS-1:0]   fwd_mag_q, trn_mag_q;
	logic                   fwd_neg_q, trn_neg_q;
	logic [AXIS_BITS+7:0]   tt_mag_q;
	side_t                  left_q, right_q;
	logic [1:0]             dir_left_q, dir_right_q;
	logic [15:0]            duty_left_q, duty_right_q;

	axis_t                  ax_x, ax_y;
	logic [AXIS_BITS-1:0]   mul_a;
	logic [GAIN_W-1:0]      mul_b;
	logic [PROD_W-1:0]      prod;
	logic [22:0]            duty_raw;
	logic [15:0]            duty_sat;
	logic signed [SUM_W-1:0] fwd_s, tt_s;
	side_t                  left_c, right_c;

	assign ax_x = axis_center(x_q, cfg.dz_lo, cfg.dz_hi);
	assign ax_y = axis_center(y_q, cfg.dz_lo, cfg.dz_hi);

	// Shared multiplier: operands chosen by the current step.
	always_comb begin
		unique case (ctl.st)
			ST_FWD: begin
				mul_a = ax_x.mag;
				mul_b = GAIN_W'(cfg.stick_gain);
			end
			ST_TRN: begin
				mul_a = ax_y.mag;
				mul_b = GAIN_W'(cfg.stick_gain);
			end
			ST_TURN: begin
				mul_a = trn_mag_q;
				mul_b = GAIN_W'(cfg.turn_gain);
			end
			ST_LEFT: begin
				mul_a = AXIS_BITS'(left_q.mag);
				mul_b = cfg.drive_gain;
			end
			ST_RIGHT: begin
				mul_a = AXIS_BITS'(right_q.mag);
				mul_b = cfg.drive_gain;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign duty_raw = prod[30:8];
	assign duty_sat = (|duty_raw[22:16]) ? 16'hFFFF : duty_raw[15:0];

	always_comb begin
		fwd_s = SUM_W'(fwd_mag_q);
		if (fwd_neg_q) fwd_s = -fwd_s;
		tt_s = SUM_W'(tt_mag_q);
		if (trn_neg_q) tt_s = -tt_s;
		left_c  = clamp_side(fwd_s + tt_s);
		right_c = clamp_side(fwd_s - tt_s);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= stick_x;
			y_q <= stick_y;
		end
		unique case (ctl.st)
			ST_FWD: begin
				fwd_mag_q <= prod[AXIS_BITS+15:16];
				fwd_neg_q <= ax_x.neg;
			end
			ST_TRN: begin
				trn_mag_q <= prod[AXIS_BITS+15:16];
				trn_neg_q <= ax_y.neg;
			end
			ST_TURN: tt_mag_q <= prod[AXIS_BITS+15:8];
			ST_MIX: begin
				left_q  <= left_c;
				right_q <= right_c;
			end
			default: ;
		endcase
	end

	// Duties are held state: a timeout reports the last sample's values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_left_q   <= DIR_OFF;
			dir_right_q  <= DIR_OFF;
			duty_left_q  <= '0;
			duty_right_q <= '0;
		end else begin
			unique case (ctl.st)
				ST_LEFT: begin
					duty_left_q <= duty_sat;
					dir_left_q  <= (left_q.mag == '0) ? DIR_OFF :
						(left_q.neg ? DIR_REV : DIR_FWD);
				end
				ST_RIGHT: begin
					duty_right_q <= duty_sat;
					dir_right_q  <= (right_q.mag == '0) ? DIR_OFF :
						(right_q.neg ? DIR_REV : DIR_FWD);
				end
				default: ;
			endcase
		end
	end

	assign dir_left   = dir_left_q;
	assign duty_left  = duty_left_q;
	assign dir_right  = dir_right_q;
	assign duty_right = duty_right_q;

endmodule

### rtl/jddm_ctrl.sv
module jddm_ctrl
	import jddm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        req_type,
	input  logic [31:0] timeout,
	input  logic        out_free,
	output logic        in_stall,
	output dp_ctl_t     ctl,
	output logic        emit,
	output logic        emit_link
);

	st_t         state_q, state_d;
	logic [31:0] idle_q;
	logic        link_q;
	logic        accept;
	logic [31:0] cnt_inc;
	logic        hit;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign cnt_inc  = (idle_q == '1) ? idle_q : idle_q + 32'd1;
	assign hit      = (cnt_inc >= timeout);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idle_q  <= '0;
			link_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (req_type == REQ_SAMPLE) begin
					idle_q <= '0;
					link_q <= 1'b1;
				end else begin
					idle_q <= hit ? '0 : cnt_inc;
					link_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		ctl.load = accept;
		ctl.st   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_SAMPLE) state_d = ST_FWD;
					else if (hit)                state_d = ST_EMIT;
				end
			end
			ST_FWD:   state_d = ST_TRN;
			ST_TRN:   state_d = ST_TURN;
			ST_TURN:  state_d = ST_MIX;
			ST_MIX:   state_d = ST_LEFT;
			ST_LEFT:  state_d = ST_RIGHT;
			ST_RIGHT: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign emit_link = link_q;

endmodule
